>>> rtl/core/afl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afl_pkg: shared definitions of the audio flanger
// Widths, constants, sequencer states and the control bundle of the shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
package afl_pkg;

  // Delay line geometry. The depth must be a power of two.
  localparam int LINE_DEPTH  = 1024;
  localparam int STORE_WIDTH = 24;
  localparam int ADDR_W      = $clog2(LINE_DEPTH);

  // Fixed field widths.
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 16;
  localparam int LEN_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Sweep position: 16.16 fixed point; the step register is one bit wider so it can hold a negated step.
  localparam int POS_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int STEP_REG_W = STEP_W + 1;
  localparam int WEIGHT_ONE = 1 << FRAC_W;

  // Blended tap sum and its split for the shared multiplier.
  localparam int SUM_W = STORE_WIDTH + FRAC_W;
  localparam int LO_W  = SUM_W / 2;
  localparam int HI_W  = SUM_W - LO_W;

  // Shared multiplier operands and accumulator.
  localparam int MAC_A_W = ((STORE_WIDTH > LO_W) ? STORE_WIDTH : LO_W) + 1;
  localparam int MAC_B_W = FRAC_W + 2;
  localparam int PROD_W  = MAC_A_W + MAC_B_W;
  localparam int ACC_W   = SUM_W + GAIN_W + 2;

  // Q2.14 gains times Q.16 sums are scaled down by 2^30.
  localparam int FRAC_SH = 30;
  localparam int Q_W     = ACC_W - FRAC_SH;

  // Sweep range arithmetic.
  localparam int RNG_W = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 2;
  localparam int CMP_W = (RNG_W > FRAC_W) ? RNG_W : FRAC_W + 1;

  localparam int OUT_LIMIT = 32000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULN,
    S_MULF,
    S_FBLO,
    S_FBHI,
    S_WETLO,
    S_WETHI,
    S_DRY,
    S_DONE
  } afl_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWEEP_STEP,
    REG_DEPTH,
    REG_DELAY,
    REG_DRY_GAIN,
    REG_WET_GAIN,
    REG_FB_GAIN
  } afl_reg_t;

  // Product alignment before accumulation.
  typedef enum logic [1:0] {
    SH_NONE,
    SH_FRAC,
    SH_HI
  } mac_shift_t;

  typedef struct packed {
    logic       en;
    logic       clear;
    mac_shift_t shift;
  } mac_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/afl_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afl_mac: shared multiply-accumulate unit
// One signed multiplier whose aligned product is added either to the running
// accumulator or to a preload value.
// ----------------------------------------------------------------------------
module afl_mac (
  input  wire logic                               clk,
  input  wire afl_pkg::mac_ctrl_t                 ctrl,
  input  wire logic signed [afl_pkg::MAC_A_W-1:0] op_a,
  input  wire logic signed [afl_pkg::MAC_B_W-1:0] op_b,
  input  wire logic signed [afl_pkg::ACC_W-1:0]   base,
  output logic signed [afl_pkg::ACC_W-1:0]        acc
);
  import afl_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_x;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;

  assign prod   = op_a * op_b;
  assign prod_x = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    case (ctrl.shift)
      SH_NONE: term = prod_x;
      SH_FRAC: term = prod_x <<< FRAC_W;
      SH_HI:   term = prod_x <<< LO_W;
      default: term = prod_x;
    endcase
    acc_nxt = (ctrl.clear ? base : acc_r) + term;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

>>> rtl/core/audio_flanger.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_flanger: modulated delay line flanger
// Interpolated two-tap read of a circular delay line with feedback, wet/dry
// mix and output clamp, computed on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Each sample is accepted in the idle step and then runs through eight steps
// of a small sequencer that drives a single 25 x 18 bit multiplier through
// seven products (two tap weights, feedback, wet and dry gains, with the
// blended sum split into halves); a new sample is taken only once the last
// one has left the final step. The finished sample waits in an output
// register, and the sequencer holds its last step while that register is
// still full. When the next sample follows at once, an output stall no
// longer than its computation is hidden behind it, and a longer stall holds
// that sample in its last step. The delay line is
// a 1024 x 24 bit memory with a registered read port; entries that have not
// yet been written since reset are recognised from the write pointer and a
// wrap flag and read as zero, so no clearing pass is needed after reset.
// Configuration writes take effect at once and should only be made while no
// transaction is in progress. The sweep starts in the middle of its range on
// the first sample after reset, taking its step size from the register at
// that moment.
// ----------------------------------------------------------------------------
module audio_flanger (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [afl_pkg::SAMPLE_W-1:0]    in_audio_in,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [afl_pkg::SAMPLE_W-1:0]         out_audio_out,
  input  wire logic                                   cfg_we,
  input  wire logic [afl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [afl_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import afl_pkg::*;

  localparam logic signed [Q_W-1:0] ST_MAX  = Q_W'((64'sd1 <<< (STORE_WIDTH-1)) - 1);
  localparam logic signed [Q_W-1:0] ST_MIN  = -ST_MAX - Q_W'(1);
  localparam logic signed [Q_W-1:0] OUT_MAX = Q_W'(OUT_LIMIT);
  localparam logic signed [Q_W-1:0] OUT_MIN = -OUT_MAX;

  // Configuration registers.
  logic signed [STEP_W-1:0] reg_step_r;
  logic [LEN_W-1:0]         reg_depth_r;
  logic [LEN_W-1:0]         reg_delay_r;
  logic signed [GAIN_W-1:0] reg_dry_r;
  logic signed [GAIN_W-1:0] reg_wet_r;
  logic signed [GAIN_W-1:0] reg_fb_r;

  // Sequencer.
  afl_state_t state_r;
  afl_state_t state_nxt;

  // Sweep and pointer state.
  logic [ADDR_W-1:0]            wr_r;
  logic [ADDR_W-1:0]            near_r;
  logic [ADDR_W-1:0]            far_r;
  logic                         wrapped_r;
  logic [POS_W-1:0]             sweep_r;
  logic signed [STEP_REG_W-1:0] step_r;
  logic                         first_r;

  // Sample payload.
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SUM_W-1:0]    s_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_data_r;

  // Delay line memory.
  logic signed [STORE_WIDTH-1:0] line_mem [LINE_DEPTH];
  logic signed [STORE_WIDTH-1:0] rd_data_r;
  logic                          rd_ok_r;
  logic [ADDR_W-1:0]             rd_addr;
  logic                          rd_ok_nxt;
  logic                          mem_we;

  // Shared multiply-accumulate unit.
  mac_ctrl_t                  mac_ctrl;
  logic signed [MAC_A_W-1:0]  op_a;
  logic signed [MAC_B_W-1:0]  op_b;
  logic signed [ACC_W-1:0]    mac_base;
  logic signed [ACC_W-1:0]    mac_acc;

  logic in_fire;
  logic done_go;

  // Range and sweep arithmetic.
  logic signed [RNG_W-1:0] top_raw;
  logic signed [RNG_W-1:0] smax;
  logic signed [RNG_W-1:0] bot_raw;
  logic signed [RNG_W-1:0] smin;
  logic signed [RNG_W-1:0] mid_sum;
  logic [FRAC_W-1:0]       mid;
  logic [ADDR_W-1:0]       wr_inc;
  logic [POS_W-1:0]        sweep_inc;
  logic [FRAC_W-1:0]       ipart;
  logic [ADDR_W-1:0]       near_inc;
  logic                    out_of_range;

  // Operands.
  logic signed [STORE_WIDTH-1:0] tap;
  logic [FRAC_W-1:0]             frac;
  logic signed [MAC_B_W-1:0]     w_near;
  logic signed [MAC_B_W-1:0]     w_far;
  logic signed [SUM_W-1:0]       s_cur;
  logic signed [MAC_A_W-1:0]     s_lo_op;
  logic signed [MAC_A_W-1:0]     s_hi_op;
  logic signed [MAC_A_W-1:0]     tap_op;
  logic signed [MAC_A_W-1:0]     x_op;
  logic signed [ACC_W-1:0]       x_base;
  logic signed [Q_W-1:0]         q_val;
  logic signed [STORE_WIDTH-1:0] store_val;
  logic signed [SAMPLE_W-1:0]    out_val;

  function automatic logic signed [MAC_B_W-1:0] gain_op(input logic signed [GAIN_W-1:0] g);
    return {{(MAC_B_W-GAIN_W){g[GAIN_W-1]}}, g};
  endfunction

  // Divide by 2^30 with truncation toward zero.
  function automatic logic signed [Q_W-1:0] trunc_q(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] bias;
    logic [ACC_W-1:0] biased;
    bias   = {{(ACC_W-FRAC_SH){1'b0}}, {FRAC_SH{v[ACC_W-1]}}};
    biased = v + bias;
    return biased[ACC_W-1:FRAC_SH];
  endfunction

  afl_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .base (mac_base),
    .acc  (mac_acc)
  );

  // The sweep range follows the current registers; a bound below zero is held at zero.
  always_comb begin
    top_raw = $signed(RNG_W'(LINE_DEPTH - 2) - RNG_W'(reg_delay_r));
    smax    = top_raw[RNG_W-1] ? '0 : top_raw;
    bot_raw = smax - $signed(RNG_W'(reg_depth_r));
    smin    = bot_raw[RNG_W-1] ? '0 : bot_raw;
    mid_sum = smin + smax;
    mid     = FRAC_W'(mid_sum >>> 1);
  end

  // Pointer and sweep advance at the end of a sample.
  always_comb begin
    wr_inc       = wr_r + 1'b1;
    sweep_inc    = sweep_r + {{(POS_W-STEP_REG_W){step_r[STEP_REG_W-1]}}, step_r};
    ipart        = sweep_inc[POS_W-1:FRAC_W];
    near_inc     = wr_inc + ipart[ADDR_W-1:0];
    out_of_range = (CMP_W'(ipart) > CMP_W'($unsigned(smax)))
                || (CMP_W'(ipart) < CMP_W'($unsigned(smin)));
  end

  // Operand preparation.
  always_comb begin
    tap     = rd_ok_r ? rd_data_r : '0;
    frac    = sweep_r[FRAC_W-1:0];
    w_near  = $signed(MAC_B_W'(frac));
    w_far   = $signed(MAC_B_W'(WEIGHT_ONE) - MAC_B_W'(frac));
    s_cur   = (state_r == S_FBLO) ? mac_acc[SUM_W-1:0] : s_r;
    s_lo_op = $signed(MAC_A_W'(s_cur[LO_W-1:0]));
    s_hi_op = {{(MAC_A_W-HI_W){s_cur[SUM_W-1]}}, s_cur[SUM_W-1:LO_W]};
    tap_op  = {{(MAC_A_W-STORE_WIDTH){tap[STORE_WIDTH-1]}}, tap};
    x_op    = {{(MAC_A_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r};
    x_base  = {{(ACC_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r} <<< FRAC_SH;
  end

  // Scaling, saturation of the recirculated value and clamp of the output.
  always_comb begin
    q_val = trunc_q(mac_acc);
    if (q_val > ST_MAX) begin
      store_val = ST_MAX[STORE_WIDTH-1:0];
    end else if (q_val < ST_MIN) begin
      store_val = ST_MIN[STORE_WIDTH-1:0];
    end else begin
      store_val = q_val[STORE_WIDTH-1:0];
    end
    if (q_val > OUT_MAX) begin
      out_val = OUT_MAX[SAMPLE_W-1:0];
    end else if (q_val < OUT_MIN) begin
      out_val = OUT_MIN[SAMPLE_W-1:0];
    end else begin
      out_val = q_val[SAMPLE_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MULN;
      S_MULN:  state_nxt = S_MULF;
      S_MULF:  state_nxt = S_FBLO;
      S_FBLO:  state_nxt = S_FBHI;
      S_FBHI:  state_nxt = S_WETLO;
      S_WETLO: state_nxt = S_WETHI;
      S_WETHI: state_nxt = S_DRY;
      S_DRY:   state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier schedule, memory strobes and handshakes.
  always_comb begin
    in_ready = 1'b0;
    done_go  = 1'b0;
    mem_we   = 1'b0;
    rd_addr  = far_r;
    mac_ctrl = '{en: 1'b0, clear: 1'b0, shift: SH_NONE};
    op_a     = tap_op;
    op_b     = w_near;
    mac_base = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = near_r;
      end
      S_MULN: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b1, shift: SH_NONE};
      end
      S_MULF: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b0, shift: SH_NONE};
        op_b     = w_far;
      end
      S_FBLO: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b1, shift: SH_NONE};
        op_a     = s_lo_op;
        op_b     = gain_op(reg_fb_r);
        mac_base = x_base;
      end
      S_FBHI: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b0, shift: SH_HI};
        op_a     = s_hi_op;
        op_b     = gain_op(reg_fb_r);
      end
      S_WETLO: begin
        mem_we   = 1'b1;
        mac_ctrl = '{en: 1'b1, clear: 1'b1, shift: SH_NONE};
        op_a     = s_lo_op;
        op_b     = gain_op(reg_wet_r);
      end
      S_WETHI: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b0, shift: SH_HI};
        op_a     = s_hi_op;
        op_b     = gain_op(reg_wet_r);
      end
      S_DRY: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b0, shift: SH_FRAC};
        op_a     = x_op;
        op_b     = gain_op(reg_dry_r);
      end
      S_DONE: begin
        done_go = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_fire   = in_valid && in_ready;
  // An entry counts as written once the write pointer has passed it since reset.
  assign rd_ok_nxt = wrapped_r || (rd_addr < wr_r);

  // Delay line: at most one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[wr_r] <= store_val;
    end
    rd_data_r <= line_mem[rd_addr];
    rd_ok_r   <= rd_ok_nxt;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r <= in_audio_in;
    end
    if (state_r == S_FBLO) begin
      s_r <= mac_acc[SUM_W-1:0];
    end
    if (done_go) begin
      out_data_r <= out_val;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_step_r  <= STEP_W'(131);
      reg_depth_r <= LEN_W'(80);
      reg_delay_r <= '0;
      reg_dry_r   <= GAIN_W'(8192);
      reg_wet_r   <= GAIN_W'(8192);
      reg_fb_r    <= '0;
    end else if (cfg_we) begin
      case (afl_reg_t'(cfg_index))
        REG_SWEEP_STEP: reg_step_r  <= cfg_wdata;
        REG_DEPTH:      reg_depth_r <= cfg_wdata[LEN_W-1:0];
        REG_DELAY:      reg_delay_r <= cfg_wdata[LEN_W-1:0];
        REG_DRY_GAIN:   reg_dry_r   <= cfg_wdata;
        REG_WET_GAIN:   reg_wet_r   <= cfg_wdata;
        REG_FB_GAIN:    reg_fb_r    <= cfg_wdata;
        default:        reg_fb_r    <= reg_fb_r;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_r        <= '0;
      near_r      <= '0;
      far_r       <= '0;
      wrapped_r   <= 1'b0;
      sweep_r     <= '0;
      step_r      <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // The first sample after reset centres the sweep and picks up the step.
      if (in_fire && first_r) begin
        first_r <= 1'b0;
        step_r  <= {reg_step_r[STEP_W-1], reg_step_r};
        sweep_r <= {mid, {FRAC_W{1'b0}}};
      end
      if (done_go) begin
        wr_r    <= wr_inc;
        near_r  <= near_inc;
        far_r   <= near_inc - 1'b1;
        sweep_r <= sweep_inc;
        if (out_of_range) begin
          step_r <= -step_r;
        end
        if (wr_r == ADDR_W'(LINE_DEPTH - 1)) begin
          wrapped_r <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_audio_out = out_data_r;

  // Checks.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_MULN))
    else $error("accepted sample did not start the multiply sequence");

  a_out_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r <= SAMPLE_W'(OUT_LIMIT))
                  && (out_data_r >= -SAMPLE_W'(OUT_LIMIT))))
    else $error("output sample outside the clamp range");

  a_wr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    done_go |=> (wr_r == ADDR_W'($past(wr_r) + 1'b1)))
    else $error("write pointer did not advance by one per sample");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented outside the final sequencer step");

endmodule
`default_nettype wire

>>> sim/audio_flanger_tb.sv
// ----------------------------------------------------------------------------
// audio_flanger_tb: self-checking testbench of the audio flanger
// Streams signed samples through the flanger with random idling on both
// channels, predicts every flanged sample with a cycle-free model of the
// delay line and sweep, and compares each output transaction against it.
// ----------------------------------------------------------------------------
module audio_flanger_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afl_pkg::*;

  // Settling time after the last output of a phase; it is long enough to
  // let the sequencer finish anything it still holds.
  localparam int SETTLE_CYCLES = 32;
  // Hard stop, far beyond the slowest legal run.
  localparam int LIMIT_NS = 5_000_000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_SAMPLES = 125;
  localparam int REPORT_CAP = 200;
  localparam longint UNITY_Q30 = 64'sd1073741824;
  localparam longint STORE_MAX = (64'sd1 <<< (STORE_WIDTH - 1)) - 1;
  localparam longint STORE_MIN = -STORE_MAX - 1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] audio_out;
    longint                     queued_at;
  } flanged_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [SAMPLE_W-1:0]   in_audio_in = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]   out_audio_out;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_wdata = '0;

  // Samples waiting to be offered, and flanged samples still owed by the block.
  logic signed [SAMPLE_W-1:0]   samples_to_send [$];
  flanged_t                     flanged_expected [$];

  int mismatch_count = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int in_gap_left = 0;
  int out_stall_left = 0;

  // Our own copy of the register file, as the block should hold it.
  logic signed [STEP_W-1:0]     step_cfg = 16'sd131;
  logic [LEN_W-1:0]             depth_cfg = 10'd80;
  logic [LEN_W-1:0]             delay_cfg = 10'd0;
  logic signed [GAIN_W-1:0]     dry_cfg = 16'sd8192;
  logic signed [GAIN_W-1:0]     wet_cfg = 16'sd8192;
  logic signed [GAIN_W-1:0]     fb_cfg = 16'sd0;

  // Our own copy of the delay line and sweep.
  logic signed [STORE_WIDTH-1:0] line_mem [LINE_DEPTH];
  logic [ADDR_W-1:0]            wr_ptr = '0;
  logic [ADDR_W-1:0]            tap_near = '0;
  logic [ADDR_W-1:0]            tap_far = '0;
  logic [POS_W-1:0]             sweep_pos = '0;
  int                           sweep_inc = 0;
  logic                         first_sample = 1'b1;

  // The opening directed samples: full-scale extremes, zero, unit values and
  // alternating bit patterns, then runs of extremes to drive the feedback
  // loop into saturation and the output into its clamp.
  logic [SAMPLE_W-1:0] opening_samples [24] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555,
    16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h3039,
    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
    16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000
  };

  audio_flanger i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_audio_in   (in_audio_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_audio_out (out_audio_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Computes the flanged sample for one accepted input sample and advances
  // the delay line, the write pointer, the sweep and both taps.
  function automatic logic signed [SAMPLE_W-1:0] flange_sample(
    input logic signed [SAMPLE_W-1:0] sample
  );
    int     top;
    int     bottom;
    int     ipart;
    longint xs;
    longint frac;
    longint blend;
    longint stored;
    longint mixed;
    logic [FRAC_W-1:0] mid;

    // Range bounds follow the live registers; negative bounds clamp to zero.
    top = LINE_DEPTH - 2 - int'(delay_cfg);
    if (top < 0) top = 0;
    bottom = top - int'(depth_cfg);
    if (bottom < 0) bottom = 0;
    xs = sample;

    // The first sample after reset latches the step and centres the sweep.
    if (first_sample) begin
      first_sample = 1'b0;
      sweep_inc = step_cfg;
      mid = FRAC_W'((bottom + top) / 2);
      sweep_pos = {mid, {FRAC_W{1'b0}}};
      wr_ptr = '0;
      tap_near = '0;
      tap_far = '0;
    end

    // Linear interpolation between the two taps, kept in Q.16.
    frac = longint'(sweep_pos[FRAC_W-1:0]);
    blend = longint'(line_mem[tap_near]) * frac
          + longint'(line_mem[tap_far]) * (longint'(WEIGHT_ONE) - frac);

    // Input plus recirculated tap, truncated towards zero, then saturated.
    stored = (xs * UNITY_Q30 + blend * longint'(fb_cfg)) / UNITY_Q30;
    if (stored > STORE_MAX) stored = STORE_MAX;
    if (stored < STORE_MIN) stored = STORE_MIN;
    line_mem[wr_ptr] = stored[STORE_WIDTH-1:0];

    // Wet and dry mix, truncated towards zero, then clamped.
    mixed = (blend * longint'(wet_cfg) + xs * 65536 * longint'(dry_cfg)) / UNITY_Q30;
    if (mixed > OUT_LIMIT) mixed = OUT_LIMIT;
    if (mixed < -OUT_LIMIT) mixed = -OUT_LIMIT;

    // The offset wraps modulo 2^32; a wrap below zero reads as a huge integer
    // part, lies above the range and so turns the sweep round.
    wr_ptr = wr_ptr + 1'b1;
    sweep_pos = sweep_pos + POS_W'(sweep_inc);
    ipart = int'(sweep_pos[POS_W-1:FRAC_W]);
    tap_near = wr_ptr + ADDR_W'(ipart);
    tap_far = tap_near - 1'b1;
    if (ipart > top || ipart < bottom) sweep_inc = -sweep_inc;
    return mixed[SAMPLE_W-1:0];
  endfunction

  // Length registers take the extremes often, including 1023, which pushes
  // the top of the sweep range below zero. Unused upper data bits are random.
  function automatic logic [CFG_DATA_W-1:0] pick_length();
    logic [LEN_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = 10'd1022;
      2: v = 10'd1023;
      3: v = LEN_W'($urandom_range(0, 40));
      default: v = LEN_W'($urandom);
    endcase
    return {(CFG_DATA_W - LEN_W)'($urandom), v};
  endfunction

  // Gains mostly sit between minus one and one in Q2.14, with those ends,
  // zero and now and then any 16-bit value at all.
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    int g;
    case ($urandom_range(0, 5))
      0: g = 16384;
      1: g = -16384;
      2: g = 0;
      3: g = int'($urandom);
      default: g = int'($urandom_range(0, 32768)) - 16384;
    endcase
    return CFG_DATA_W'(g);
  endfunction

  // Writes one register and mirrors the write into the prediction copy. Only
  // ever called while no transaction is in flight.
  task automatic write_reg(input afl_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_SWEEP_STEP: step_cfg = value[STEP_W-1:0];
      REG_DEPTH:      depth_cfg = value[LEN_W-1:0];
      REG_DELAY:      delay_cfg = value[LEN_W-1:0];
      REG_DRY_GAIN:   dry_cfg = value[GAIN_W-1:0];
      REG_WET_GAIN:   wet_cfg = value[GAIN_W-1:0];
      REG_FB_GAIN:    fb_cfg = value[GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued sample has been accepted and every flanged
  // sample has come back, then lets the sequencer settle.
  task automatic await_drain();
    while (samples_to_send.size() != 0 || in_valid || flanged_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver. On each accepted transaction the expected flanged sample
  // is worked out at once, stamped with the current simulation time so that
  // the monitor never pairs an output with a sample taken in the same cycle.
  // A new sample is only presented once the previous one has gone, and idle
  // bursts are inserted between transactions, never inside one.
  always @(posedge clk) begin
    flanged_t entry;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        entry.audio_out = flange_sample(in_audio_in);
        entry.queued_at = $time;
        flanged_expected.push_back(entry);
      end
      if (!in_valid || in_ready) begin
        if (in_gap_left > 0) begin
          in_gap_left = in_gap_left - 1;
          in_valid <= 1'b0;
        end else if (samples_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < in_gap_pct) begin
          in_gap_left = $urandom_range(1, 8) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_audio_in <= samples_to_send.pop_front();
        end
      end
    end
  end

  // Output monitor. Each output transaction is checked against the oldest
  // outstanding prediction. Back-pressure comes in random bursts; the report
  // count is capped so that a badly broken block cannot flood the log.
  always @(posedge clk) begin
    flanged_t oldest;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (flanged_expected.size() == 0 || flanged_expected[0].queued_at == $time) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t ns: unexpected output transaction, expected none, actual %0d",
                     $time, out_audio_out);
        end else begin
          oldest = flanged_expected.pop_front();
          if (out_audio_out !== oldest.audio_out) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
              $display("%0t ns: audio_out mismatch, expected %0d, actual %0d",
                       $time, oldest.audio_out, out_audio_out);
          end
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left = out_stall_left - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        out_stall_left = $urandom_range(1, 8) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence: reset, two short directed phases, then random phases
  // each under a fresh register setting. The last phase runs with both
  // channels flat out.
  initial begin : stimulus
    int phase;
    int k;

    foreach (line_mem[i]) line_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The step is latched by the first sample only, so it is set here, before
    // any transaction. Depth and delay of 1023 push both range bounds below
    // zero, so the sweep starts at offset zero and swings across it, wrapping
    // the offset below zero. The gains are left at their reset values.
    in_gap_pct = 10;
    out_stall_pct = 10;
    write_reg(REG_SWEEP_STEP, 16'h7FFF);
    write_reg(REG_DEPTH, 16'hFFFF);
    write_reg(REG_DELAY, 16'hFFFF);
    for (k = 0; k < 12; k++) samples_to_send.push_back(opening_samples[k]);
    await_drain();

    // A collapsed range at the top of the line, so the taps sit right behind
    // the write pointer; full dry gain, inverted wet gain and a feedback gain
    // of minus two drive the store into saturation and the output into clamp.
    write_reg(REG_DEPTH, 16'h0000);
    write_reg(REG_DELAY, 16'h0000);
    write_reg(REG_DRY_GAIN, 16'h4000);
    write_reg(REG_WET_GAIN, 16'hC000);
    write_reg(REG_FB_GAIN, 16'h8000);
    for (k = 12; k < 24; k++) samples_to_send.push_back(opening_samples[k]);
    await_drain();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(REG_SWEEP_STEP, CFG_DATA_W'($urandom));
      write_reg(REG_DEPTH, pick_length());
      write_reg(REG_DELAY, pick_length());
      write_reg(REG_DRY_GAIN, pick_gain());
      write_reg(REG_WET_GAIN, pick_gain());
      write_reg(REG_FB_GAIN, pick_gain());
      if (phase == RANDOM_PHASES - 1) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct = 10 * $urandom_range(0, 2);
        out_stall_pct = 10 * $urandom_range(0, 2);
      end
      for (k = 0; k < PHASE_SAMPLES; k++) begin
        case ($urandom_range(0, 9))
          0: samples_to_send.push_back(16'sh7FFF);
          1: samples_to_send.push_back(16'sh8000);
          2, 3: samples_to_send.push_back(SAMPLE_W'($urandom_range(0, 64) - 32));
          default: samples_to_send.push_back(SAMPLE_W'($urandom));
        endcase
      end
      await_drain();
    end

    if (mismatch_count == 0 && flanged_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #LIMIT_NS;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
